>>> hdl/qrle_pkg.sv
package qrle_pkg;

    localparam int BYTE_W    = 8;
    localparam int RUN_W     = 6;
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;
    localparam int CH_W      = 3;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam int MAX_RUN_DEFAULT = 62;

    localparam logic [BYTE_W-1:0] OP_RUN  = 8'hC0;
    localparam logic [BYTE_W-1:0] OP_RGB  = 8'hFE;
    localparam logic [BYTE_W-1:0] OP_RGBA = 8'hFF;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [CH_W-1:0] CH_RGBA  = 3'd4;
    localparam logic [CH_W-1:0] CH_RESET = 3'd4;

    // Register index taken from paddr[2]
    localparam logic REG_CHANNEL_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] CNT_NONE     = 3'd0;
    localparam logic [CNT_W-1:0] CNT_RUN      = 3'd1;
    localparam logic [CNT_W-1:0] CNT_RGB      = 3'd4;
    localparam logic [CNT_W-1:0] CNT_RGBA     = 3'd5;
    localparam logic [CNT_W-1:0] CNT_RUN_RGB  = 3'd5;
    localparam logic [CNT_W-1:0] CNT_RUN_RGBA = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
    } pixel_t;

    localparam pixel_t PIXEL_RESET = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hFF};

    typedef struct packed {
        pixel_t pixel;
        logic   rgba;
        logic   last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;   // bytes[0] goes out first
        logic [CNT_W-1:0]                 count;
    } packet_t;

endpackage

>>> hdl/qoi_run_literal_pixel_encoder.sv
// Run-and-literal pixel encoder (subset of the QOI byte stream).
// Input channel s_*: one pixel per transaction, with s_last_pixel marking
// the final pixel of an image. Output channel m_*: one encoded byte per
// transaction; m_last_byte flags the final byte caused by a pixel.
// A pixel matching the previous one extends a run and emits nothing until
// the run reaches MAX_RUN or the last pixel; a different pixel flushes any
// pending run and emits an RGB (4 bytes) or RGBA (5 bytes) literal.
// The APB register at address 0 holds channel_count (4 = RGBA, anything
// else = RGB with alpha taken as 255); write it only while idle.
// A pixel accepted on s_* is captured in the input register, encoded
// combinationally and loaded into the byte packet register, from which
// its first byte is offered on m_*. Pixel throughput is set by the single
// byte-wide output port; up to six bytes for a run flush plus RGBA literal.
// The next packet loads as the final byte of the current one is taken.
// When m_ready is low, the current packet holds; a pixel that only extends
// a run still passes, but one with bytes to emit waits in the input
// register, after which s_ready drops.
// Reset (aresetn low, synchronous) empties both stages, clears the run,
// sets the previous pixel to black with alpha 255, and channel_count to 4.
module qoi_run_literal_pixel_encoder #(
    parameter int MAX_RUN = qrle_pkg::MAX_RUN_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qrle_pkg::ADDR_W-1:0]   paddr,
    input  logic [qrle_pkg::DATA_W-1:0]   pwdata,
    output logic [qrle_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [qrle_pkg::BYTE_W-1:0]   s_red,
    input  logic [qrle_pkg::BYTE_W-1:0]   s_green,
    input  logic [qrle_pkg::BYTE_W-1:0]   s_blue,
    input  logic [qrle_pkg::BYTE_W-1:0]   s_alpha,
    input  logic                          s_last_pixel,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qrle_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_last_byte
);

    logic [qrle_pkg::CH_W-1:0] channel_count_reg;
    logic                      reg_sel;
    logic                      rgba;

    qrle_pkg::in_item_t        item_reg;
    qrle_pkg::in_item_t        item_next;
    logic                      item_valid_reg;
    logic                      item_advance;
    logic                      pkt_load;
    logic                      pkt_ready;
    qrle_pkg::packet_t         pkt;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == qrle_pkg::REG_CHANNEL_COUNT);
    assign prdata  = reg_sel ? qrle_pkg::DATA_W'(channel_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= qrle_pkg::CH_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            channel_count_reg <= pwdata[qrle_pkg::CH_W-1:0];
        end
    end

    // Input register: force alpha in RGB mode at capture
    assign rgba    = (channel_count_reg == qrle_pkg::CH_RGBA);
    assign s_ready = !item_valid_reg || item_advance;

    always_comb begin
        item_next.pixel.red   = s_red;
        item_next.pixel.green = s_green;
        item_next.pixel.blue  = s_blue;
        item_next.pixel.alpha = rgba ? s_alpha : qrle_pkg::ALPHA_OPAQUE;
        item_next.rgba        = rgba;
        item_next.last_pixel  = s_last_pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

    qrle_encoder #(
        .MAX_RUN (MAX_RUN)
    ) u_encoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .pkt_ready    (pkt_ready),
        .item_advance (item_advance),
        .pkt_load     (pkt_load),
        .pkt          (pkt)
    );

    qrle_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pkt_load  (pkt_load),
        .pkt       (pkt),
        .pkt_ready (pkt_ready),
        .out_byte  (m_out_byte),
        .last_byte (m_last_byte),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

endmodule

>>> hdl/qrle_encoder.sv
module qrle_encoder #(
    parameter int MAX_RUN = qrle_pkg::MAX_RUN_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  qrle_pkg::in_item_t  item,
    input  logic                pkt_ready,
    output logic                item_advance,
    output logic                pkt_load,
    output qrle_pkg::packet_t   pkt
);

    qrle_pkg::pixel_t             prev_reg;
    qrle_pkg::pixel_t             prev_next;
    logic [qrle_pkg::RUN_W-1:0]   run_reg;
    logic [qrle_pkg::RUN_W-1:0]   run_next;
    logic [qrle_pkg::RUN_W-1:0]   run_inc;
    logic [qrle_pkg::BYTE_W-1:0]  run_byte;
    logic [qrle_pkg::BYTE_W-1:0]  op_byte;
    logic                         same;
    logic                         flush;

    assign same     = (item.pixel == prev_reg);
    assign run_inc  = run_reg + 1'b1;
    assign flush    = (run_reg != '0);
    assign op_byte  = item.rgba ? qrle_pkg::OP_RGBA : qrle_pkg::OP_RGB;

    always_comb begin
        pkt.bytes = '0;
        pkt.count = qrle_pkg::CNT_NONE;
        run_next  = '0;
        // run byte stores run-1; for a run that ends here that is the old count
        run_byte  = qrle_pkg::OP_RUN | {2'b00, (same ? run_reg : run_reg - 1'b1)};
        if (same) begin
            if (run_inc >= qrle_pkg::RUN_W'(MAX_RUN) || item.last_pixel) begin
                pkt.bytes[0] = run_byte;
                pkt.count    = qrle_pkg::CNT_RUN;
            end else begin
                run_next = run_inc;
            end
        end else if (flush) begin
            pkt.bytes[0] = run_byte;
            pkt.bytes[1] = op_byte;
            pkt.bytes[2] = item.pixel.red;
            pkt.bytes[3] = item.pixel.green;
            pkt.bytes[4] = item.pixel.blue;
            pkt.bytes[5] = item.pixel.alpha;
            pkt.count    = item.rgba ? qrle_pkg::CNT_RUN_RGBA : qrle_pkg::CNT_RUN_RGB;
        end else begin
            pkt.bytes[0] = op_byte;
            pkt.bytes[1] = item.pixel.red;
            pkt.bytes[2] = item.pixel.green;
            pkt.bytes[3] = item.pixel.blue;
            pkt.bytes[4] = item.pixel.alpha;
            pkt.count    = item.rgba ? qrle_pkg::CNT_RGBA : qrle_pkg::CNT_RGB;
        end
    end

    // An item that makes no bytes never waits on the serializer
    assign pkt_load     = item_valid && (pkt.count != qrle_pkg::CNT_NONE);
    assign item_advance = item_valid && ((pkt.count == qrle_pkg::CNT_NONE) || pkt_ready);
    assign prev_next    = item.pixel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= qrle_pkg::PIXEL_RESET;
            run_reg  <= '0;
        end else if (item_advance) begin
            prev_reg <= prev_next;
            run_reg  <= run_next;
        end
    end

endmodule

>>> hdl/qrle_serializer.sv
module qrle_serializer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pkt_load,
    input  qrle_pkg::packet_t             pkt,
    output logic                          pkt_ready,
    output logic [qrle_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready
);

    logic [qrle_pkg::MAX_BYTES-1:0][qrle_pkg::BYTE_W-1:0] bytes_reg;
    logic [qrle_pkg::MAX_BYTES-1:0][qrle_pkg::BYTE_W-1:0] bytes_next;
    logic [qrle_pkg::CNT_W-1:0]                           left_reg;
    logic [qrle_pkg::CNT_W-1:0]                           left_next;
    logic                                                 take;

    assign out_valid = (left_reg != '0);
    assign out_byte  = bytes_reg[0];
    assign last_byte = (left_reg == qrle_pkg::CNT_RUN);
    assign take      = out_valid && out_ready;
    // Free now, or the final byte leaves this cycle
    assign pkt_ready = !out_valid || (take && last_byte);

    always_comb begin
        bytes_next = bytes_reg;
        left_next  = left_reg;
        if (pkt_load && pkt_ready) begin
            bytes_next = pkt.bytes;
            left_next  = pkt.count;
        end else if (take) begin
            // advance to the next byte of the packet
            bytes_next = {{qrle_pkg::BYTE_W{1'b0}},
                          bytes_reg[qrle_pkg::MAX_BYTES-1:1]};
            left_next  = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

endmodule
